[hdl/sorted_timer_queue_defines.svh]
// ----------------------------------------------------------------------------
// sorted_timer_queue_defines
// Assertion macros shared by the sorted timer queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;

    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 4;
    localparam int DELAY_BITS  = 32;
    localparam int NOW_BITS    = 48;
    localparam int KIND_BITS   = 2;
    localparam int REMAIN_BITS = 48;
    localparam int PROD_BITS   = DELAY_BITS + 10;

    localparam int US_PER_MS = 1000;

    localparam logic [REMAIN_BITS-1:0] REMAIN_MAX = '1;

    localparam logic [OP_BITS-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_BITS-1:0] OP_EXPIRE = 2'd2;
    localparam logic [OP_BITS-1:0] OP_STATUS = 2'd3;

    localparam logic [KIND_BITS-1:0] KIND_EXPIRED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMAIN  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_ACK     = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_POP,
        CELL_KILL,
        CELL_BUBBLE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [ID_BITS-1:0] id;
    } cell_ctl_t;

    typedef struct packed {
        logic               valid;
        logic [ID_BITS-1:0] owner;
        logic               goes_right;
        logic               take_right;
    } link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DEADLINE,
        ST_KILL,
        ST_BUBBLE,
        ST_INSERT,
        ST_ACK,
        ST_EXPIRE
    } state_t;

endpackage

[hdl/stq_channels.sv]
// ----------------------------------------------------------------------------
// stq_channels
// Valid/ready channels for commands into and events out of the timer queue.
// ----------------------------------------------------------------------------
interface stq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [stq_pkg::OP_BITS-1:0]      op;
    logic [stq_pkg::ID_BITS-1:0]      timer_id;
    logic [stq_pkg::DELAY_BITS-1:0]   delay_ms;
    logic [stq_pkg::NOW_BITS-1:0]     now_us;

    modport source (output valid, op, timer_id, delay_ms, now_us, input ready);
    modport sink   (input valid, op, timer_id, delay_ms, now_us, output ready);
endinterface

interface stq_evt_if;
    logic                             valid;
    logic                             ready;
    logic [stq_pkg::KIND_BITS-1:0]    kind;
    logic [stq_pkg::ID_BITS-1:0]      expired_id;
    logic [stq_pkg::REMAIN_BITS-1:0]  remaining_us;
    logic                             is_queued;
    logic                             error;
    logic                             last;

    modport source (output valid, kind, expired_id, remaining_us, is_queued, error, last,
                    input ready);
    modport sink   (input valid, kind, expired_id, remaining_us, is_queued, error, last,
                    output ready);
endinterface

[hdl/stq_cell.sv]
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted row: holds a deadline and its owner, and shifts
// left or right with its neighbors on pop, unlink and insert.
// ----------------------------------------------------------------------------
module stq_cell #(
    parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stq_pkg::cell_ctl_t    ctl,
    input  logic [TIME_BITS-1:0]  new_dl,
    input  stq_pkg::link_t        left_link,
    input  logic [TIME_BITS-1:0]  left_dl,
    input  stq_pkg::link_t        right_link,
    input  logic [TIME_BITS-1:0]  right_dl,
    output stq_pkg::link_t        link,
    output logic [TIME_BITS-1:0]  dl
);

    logic                         v_reg;
    logic                         v_next;
    logic                         tok_reg;
    logic                         tok_next;
    logic [stq_pkg::ID_BITS-1:0]  own_reg;
    logic [stq_pkg::ID_BITS-1:0]  own_next;
    logic [TIME_BITS-1:0]         dl_reg;
    logic [TIME_BITS-1:0]         dl_next;

    logic match;
    logic goes_right;
    logic take_right;

    always_comb
    begin
        match      = v_reg && (own_reg == ctl.id) && (ctl.op == stq_pkg::CELL_KILL);
        goes_right = !v_reg || (new_dl < dl_reg);
        take_right = ((ctl.op == stq_pkg::CELL_BUBBLE) && tok_reg) || match;

        link.valid      = v_reg;
        link.owner      = own_reg;
        link.goes_right = goes_right;
        link.take_right = take_right;
    end

    assign dl = dl_reg;

    always_comb
    begin
        v_next   = v_reg;
        own_next = own_reg;
        dl_next  = dl_reg;
        // unlink hole travels right one slot per cycle
        tok_next = left_link.take_right && v_reg;
        case (ctl.op)
            stq_pkg::CELL_POP:
            begin
                v_next   = right_link.valid;
                own_next = right_link.owner;
                dl_next  = right_dl;
            end
            stq_pkg::CELL_KILL,
            stq_pkg::CELL_BUBBLE:
            begin
                if (take_right)
                begin
                    v_next   = right_link.valid;
                    own_next = right_link.owner;
                    dl_next  = right_dl;
                end
            end
            stq_pkg::CELL_INSERT:
            begin
                if (goes_right)
                begin
                    if (left_link.goes_right)
                    begin
                        v_next   = left_link.valid;
                        own_next = left_link.owner;
                        dl_next  = left_dl;
                    end
                    else
                    begin
                        v_next   = 1'b1;
                        own_next = ctl.id;
                        dl_next  = new_dl;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= v_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        own_reg <= own_next;
        dl_reg  <= dl_next;
    end

endmodule

[hdl/stq_chain.sv]
// ----------------------------------------------------------------------------
// stq_chain
// Row of slot cells kept in deadline order, head at the left end.
// ----------------------------------------------------------------------------
module stq_chain #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stq_pkg::cell_ctl_t    ctl,
    input  logic [TIME_BITS-1:0]  new_dl,
    output stq_pkg::link_t        head_link,
    output logic [TIME_BITS-1:0]  head_dl
);

    stq_pkg::link_t        links [NUM_TIMERS];
    logic [TIME_BITS-1:0]  dls   [NUM_TIMERS];
    stq_pkg::link_t        lft_link [NUM_TIMERS];
    logic [TIME_BITS-1:0]  lft_dl   [NUM_TIMERS];
    stq_pkg::link_t        rgt_link [NUM_TIMERS];
    logic [TIME_BITS-1:0]  rgt_dl   [NUM_TIMERS];

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign lft_link[g] = '0;
            assign lft_dl[g]   = '0;
        end
        else
        begin : g_inner_l
            assign lft_link[g] = links[g-1];
            assign lft_dl[g]   = dls[g-1];
        end

        if (g == NUM_TIMERS - 1)
        begin : g_last
            assign rgt_link[g] = '0;
            assign rgt_dl[g]   = '0;
        end
        else
        begin : g_inner_r
            assign rgt_link[g] = links[g+1];
            assign rgt_dl[g]   = dls[g+1];
        end

        stq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_dl     (new_dl),
            .left_link  (lft_link[g]),
            .left_dl    (lft_dl[g]),
            .right_link (rgt_link[g]),
            .right_dl   (rgt_dl[g]),
            .link       (links[g]),
            .dl         (dls[g])
        );
    end

    assign head_link = links[0];
    assign head_dl   = dls[0];

endmodule

[hdl/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Sorted deadline queue of numbered timers with arm, cancel, expire and
// status commands.
// ----------------------------------------------------------------------------
// Timers sit in a row of cells sorted by deadline in microseconds, earliest
// at the head; equal deadlines keep arm order. One command transaction is
// handled at a time. Status and cancel of an idle timer go straight to the
// acknowledge. Cancel of a queued timer first unlinks it; arm computes the
// deadline, unlinks the timer if it was already queued and inserts it if a
// cell is free (an id outside the queue skips both), and expire pops every
// due timer before its closing event. Events wait while the event side holds
// ready low. Unlinking walks the hole that moves one cell per cycle down the
// row after a timer is removed from the middle; pops from the head and
// inserts are single steps. Arm computes the deadline with one 32x10
// multiply followed by a saturating add, each in its own state.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = stq_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    stq_cmd_if.sink   cmd,
    stq_evt_if.source evt
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int SW = ((TIME_BITS > stq_pkg::PROD_BITS) ? TIME_BITS : stq_pkg::PROD_BITS) + 1;
    localparam int RW = (TIME_BITS > stq_pkg::REMAIN_BITS) ? TIME_BITS : stq_pkg::REMAIN_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    stq_pkg::state_t state_reg;
    stq_pkg::state_t state_next;

    logic [stq_pkg::OP_BITS-1:0]     op_reg;
    logic [stq_pkg::OP_BITS-1:0]     op_next;
    logic [stq_pkg::ID_BITS-1:0]     id_reg;
    logic [stq_pkg::ID_BITS-1:0]     id_next;
    logic [stq_pkg::DELAY_BITS-1:0]  delay_reg;
    logic [stq_pkg::DELAY_BITS-1:0]  delay_next;
    logic [TIME_BITS-1:0]            now_reg;
    logic [TIME_BITS-1:0]            now_next;
    logic [stq_pkg::PROD_BITS-1:0]   prod_reg;
    logic [stq_pkg::PROD_BITS-1:0]   prod_next;
    logic [TIME_BITS-1:0]            dl_reg;
    logic [TIME_BITS-1:0]            dl_next;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic [CW-1:0]                   bub_reg;
    logic [CW-1:0]                   bub_next;
    logic [NUM_TIMERS-1:0]           mask_reg;
    logic [NUM_TIMERS-1:0]           mask_next;
    logic                            ack_q_reg;
    logic                            ack_q_next;
    logic                            ack_err_reg;
    logic                            ack_err_next;

    logic                              ovalid_reg;
    logic                              ovalid_next;
    logic [stq_pkg::KIND_BITS-1:0]     okind_reg;
    logic [stq_pkg::KIND_BITS-1:0]     okind_next;
    logic [stq_pkg::ID_BITS-1:0]       oid_reg;
    logic [stq_pkg::ID_BITS-1:0]       oid_next;
    logic [stq_pkg::REMAIN_BITS-1:0]   orem_reg;
    logic [stq_pkg::REMAIN_BITS-1:0]   orem_next;
    logic                              oq_reg;
    logic                              oq_next;
    logic                              oerr_reg;
    logic                              oerr_next;
    logic                              olast_reg;
    logic                              olast_next;

    stq_pkg::cell_ctl_t    ctl;
    stq_pkg::link_t        head_link;
    logic [TIME_BITS-1:0]  head_dl;

    logic                  slot_free;
    logic                  pop_fire;
    logic                  in_id_ok;
    logic                  id_ok;
    logic [IW-1:0]         in_idx;
    logic [IW-1:0]         idx;
    logic [IW-1:0]         head_idx;
    logic [SW-1:0]         sum_w;
    logic [TIME_BITS-1:0]  dl_sat;
    logic [TIME_BITS-1:0]  rem_full;
    logic [RW-1:0]         rem_ext;
    logic [stq_pkg::REMAIN_BITS-1:0] rem_out;

    assign in_id_ok = 32'(cmd.timer_id) < NUM_TIMERS;
    assign id_ok    = 32'(id_reg) < NUM_TIMERS;
    assign in_idx   = IW'(cmd.timer_id);
    assign idx      = IW'(id_reg);
    assign head_idx = IW'(head_link.owner);

    assign sum_w  = SW'(now_reg) + SW'(prod_reg);
    assign dl_sat = (sum_w > SW'(TIME_MAX)) ? TIME_MAX : sum_w[TIME_BITS-1:0];

    assign rem_full = head_dl - now_reg;
    assign rem_ext  = RW'(rem_full);
    assign rem_out  = (rem_ext > RW'(stq_pkg::REMAIN_MAX)) ? stq_pkg::REMAIN_MAX
                                                         : rem_ext[stq_pkg::REMAIN_BITS-1:0];

    assign slot_free = !ovalid_reg || evt.ready;

    assign cmd.ready        = (state_reg == stq_pkg::ST_IDLE);
    assign evt.valid        = ovalid_reg;
    assign evt.kind         = okind_reg;
    assign evt.expired_id   = oid_reg;
    assign evt.remaining_us = orem_reg;
    assign evt.is_queued    = oq_reg;
    assign evt.error        = oerr_reg;
    assign evt.last         = olast_reg;

    stq_chain #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_dl    (dl_reg),
        .head_link (head_link),
        .head_dl   (head_dl)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        delay_next   = delay_reg;
        now_next     = now_reg;
        prod_next    = prod_reg;
        dl_next      = dl_reg;
        cnt_next     = cnt_reg;
        bub_next     = bub_reg;
        mask_next    = mask_reg;
        ack_q_next   = ack_q_reg;
        ack_err_next = ack_err_reg;

        ovalid_next = evt.ready ? 1'b0 : ovalid_reg;
        okind_next  = okind_reg;
        oid_next    = oid_reg;
        orem_next   = orem_reg;
        oq_next     = oq_reg;
        oerr_next   = oerr_reg;
        olast_next  = olast_reg;

        ctl.op   = stq_pkg::CELL_HOLD;
        ctl.id   = id_reg;
        pop_fire = 1'b0;

        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next      = cmd.op;
                    id_next      = cmd.timer_id;
                    delay_next   = cmd.delay_ms;
                    now_next     = TIME_BITS'(cmd.now_us);
                    ack_q_next   = (cmd.op == stq_pkg::OP_STATUS) && in_id_ok && mask_reg[in_idx];
                    ack_err_next = (cmd.op == stq_pkg::OP_ARM);
                    case (cmd.op)
                        stq_pkg::OP_ARM:
                            state_next = stq_pkg::ST_MUL;
                        stq_pkg::OP_CANCEL:
                            state_next = (in_id_ok && mask_reg[in_idx]) ? stq_pkg::ST_KILL
                                                                        : stq_pkg::ST_ACK;
                        stq_pkg::OP_EXPIRE:
                            state_next = stq_pkg::ST_EXPIRE;
                        default:
                            state_next = stq_pkg::ST_ACK;
                    endcase
                end
            end
            stq_pkg::ST_MUL:
            begin
                prod_next  = stq_pkg::PROD_BITS'(delay_reg)
                           * stq_pkg::PROD_BITS'(stq_pkg::US_PER_MS);
                state_next = stq_pkg::ST_DEADLINE;
            end
            stq_pkg::ST_DEADLINE:
            begin
                dl_next = dl_sat;
                if (!id_ok)
                    state_next = stq_pkg::ST_ACK;
                else if (mask_reg[idx])
                    state_next = stq_pkg::ST_KILL;
                else
                    state_next = stq_pkg::ST_INSERT;
            end
            stq_pkg::ST_KILL:
            begin
                ctl.op         = stq_pkg::CELL_KILL;
                mask_next[idx] = 1'b0;
                cnt_next       = cnt_reg - CW'(1);
                bub_next       = cnt_reg;
                state_next     = stq_pkg::ST_BUBBLE;
            end
            stq_pkg::ST_BUBBLE:
            begin
                ctl.op   = stq_pkg::CELL_BUBBLE;
                bub_next = bub_reg - CW'(1);
                if (bub_reg <= CW'(1))
                    state_next = (op_reg == stq_pkg::OP_ARM) ? stq_pkg::ST_INSERT
                                                             : stq_pkg::ST_ACK;
            end
            stq_pkg::ST_INSERT:
            begin
                if (cnt_reg != CW'(NUM_TIMERS))
                begin
                    ctl.op         = stq_pkg::CELL_INSERT;
                    mask_next[idx] = 1'b1;
                    cnt_next       = cnt_reg + CW'(1);
                    ack_q_next     = 1'b1;
                    ack_err_next   = 1'b0;
                end
                state_next = stq_pkg::ST_ACK;
            end
            stq_pkg::ST_ACK:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = stq_pkg::KIND_ACK;
                    oid_next    = id_reg;
                    orem_next   = '0;
                    oq_next     = ack_q_reg;
                    oerr_next   = ack_err_reg;
                    olast_next  = 1'b1;
                    state_next  = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_EXPIRE:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oq_next     = 1'b0;
                    oerr_next   = 1'b0;
                    orem_next   = '0;
                    oid_next    = '0;
                    if (head_link.valid && (head_dl <= now_reg))
                    begin
                        ctl.op              = stq_pkg::CELL_POP;
                        pop_fire            = 1'b1;
                        mask_next[head_idx] = 1'b0;
                        cnt_next            = cnt_reg - CW'(1);
                        okind_next          = stq_pkg::KIND_EXPIRED;
                        oid_next            = head_link.owner;
                        olast_next          = 1'b0;
                    end
                    else
                    begin
                        olast_next = 1'b1;
                        state_next = stq_pkg::ST_IDLE;
                        if (head_link.valid)
                        begin
                            okind_next = stq_pkg::KIND_REMAIN;
                            orem_next  = rem_out;
                        end
                        else
                        begin
                            okind_next = stq_pkg::KIND_EMPTY;
                        end
                    end
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stq_pkg::ST_IDLE;
            cnt_reg    <= '0;
            bub_reg    <= '0;
            mask_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bub_reg    <= bub_next;
            mask_reg   <= mask_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        delay_reg   <= delay_next;
        now_reg     <= now_next;
        prod_reg    <= prod_next;
        dl_reg      <= dl_next;
        ack_q_reg   <= ack_q_next;
        ack_err_reg <= ack_err_next;
        okind_reg   <= okind_next;
        oid_reg     <= oid_next;
        orem_reg    <= orem_next;
        oq_reg      <= oq_next;
        oerr_reg    <= oerr_next;
        olast_reg   <= olast_next;
    end

    // queued flags and slot count stay in step
    `STQ_ASSERT_NOW(a_mask_count, 1'b1, $countones(mask_reg) == cnt_reg, "mask/count mismatch")
    // while idle, the head of the row is occupied exactly when the queue is not empty
    `STQ_ASSERT_NOW(a_head_valid, state_reg == stq_pkg::ST_IDLE,
                    head_link.valid == (cnt_reg != '0), "head/count mismatch")
    // every pop removes exactly one timer
    `STQ_ASSERT_NEXT(a_pop_count, pop_fire, cnt_reg == $past(cnt_reg) - CW'(1),
                     "pop count error")

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timer queue.
// ----------------------------------------------------------------------------
// Commands go in over the command channel. A predictor keeps its own sorted
// list of deadlines and owners and turns every accepted command into the
// events it must cause. Each event taken from the event channel is compared
// field by field with the oldest prediction. Directed tests cover the empty
// queue, tie order, re-arm and cancel and deadline saturation.
// Random traffic follows with fill-and-drain bursts, odd items and a stretch
// with no stalls on either side.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    localparam int TIMERS         = NUM_TIMERS_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [KIND_BITS-1:0]   kind;
        logic [ID_BITS-1:0]     expired_id;
        logic [REMAIN_BITS-1:0] remaining_us;
        logic                   is_queued;
        logic                   error;
        logic                   last;
    } timer_event_t;

    logic clk;
    logic rst_n;

    stq_cmd_if cmd_bus ();
    stq_evt_if evt_bus ();

    sorted_timer_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .evt   (evt_bus)
    );

    timer_event_t           upcoming_events[$];
    logic [NOW_BITS-1:0]    line_deadline[TIMERS];
    logic [ID_BITS-1:0]     line_owner[TIMERS];
    int                     line_count;
    logic [TIMERS-1:0]      armed_mask;
    logic [NOW_BITS-1:0]    wall_us;
    bit                     stall_enable;
    int                     error_count;
    int                     quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit take_break();
        return stall_enable && ($urandom_range(0, 99) < 25);
    endfunction

    function automatic void note_event(input logic [KIND_BITS-1:0] kind,
                                       input logic [ID_BITS-1:0] id,
                                       input logic [REMAIN_BITS-1:0] remaining,
                                       input logic queued, input logic err,
                                       input logic last);
        timer_event_t ev;
        ev.kind         = kind;
        ev.expired_id   = id;
        ev.remaining_us = remaining;
        ev.is_queued    = queued;
        ev.error        = err;
        ev.last         = last;
        upcoming_events.push_back(ev);
    endfunction

    function automatic void remove_line(input int pos);
        for (int i = pos; i + 1 < line_count; i++)
        begin
            line_deadline[i] = line_deadline[i + 1];
            line_owner[i]    = line_owner[i + 1];
        end
        if (line_count > 0)
            line_count--;
    endfunction

    function automatic void drop_timer(input logic [ID_BITS-1:0] id);
        if (!armed_mask[id])
            return;
        armed_mask[id] = 1'b0;
        for (int i = 0; i < line_count; i++)
        begin
            if (line_owner[i] == id)
            begin
                remove_line(i);
                return;
            end
        end
    endfunction

    function automatic bit place_timer(input logic [ID_BITS-1:0] id,
                                       input logic [NOW_BITS-1:0] deadline);
        int pos;
        pos = 0;
        if (line_count >= TIMERS)
            return 1'b0;
        while (pos < line_count && !(deadline < line_deadline[pos]))
            pos++;
        for (int i = line_count; i > pos; i--)
        begin
            line_deadline[i] = line_deadline[i - 1];
            line_owner[i]    = line_owner[i - 1];
        end
        line_deadline[pos] = deadline;
        line_owner[pos]    = id;
        line_count++;
        armed_mask[id] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void model_command(input logic [OP_BITS-1:0] op,
                                          input logic [ID_BITS-1:0] id,
                                          input logic [DELAY_BITS-1:0] delay,
                                          input logic [NOW_BITS-1:0] now);
        logic [63:0]          product;
        logic [63:0]          room;
        logic [NOW_BITS-1:0]  deadline;
        logic [ID_BITS-1:0]   who;
        bit                   ok;
        case (op)
            OP_ARM:
            begin
                product  = 64'(delay) * 64'(US_PER_MS);
                room     = 64'(REMAIN_MAX) - 64'(now);
                deadline = (product > room) ? REMAIN_MAX : now + NOW_BITS'(product);
                drop_timer(id);
                ok = place_timer(id, deadline);
                note_event(KIND_ACK, id, '0, ok, !ok, 1'b1);
            end
            OP_CANCEL:
            begin
                drop_timer(id);
                note_event(KIND_ACK, id, '0, 1'b0, 1'b0, 1'b1);
            end
            OP_STATUS:
                note_event(KIND_ACK, id, '0, armed_mask[id], 1'b0, 1'b1);
            default:
            begin
                while (line_count > 0 && line_deadline[0] <= now)
                begin
                    who = line_owner[0];
                    armed_mask[who] = 1'b0;
                    remove_line(0);
                    note_event(KIND_EXPIRED, who, '0, 1'b0, 1'b0, 1'b0);
                end
                if (line_count == 0)
                    note_event(KIND_EMPTY, '0, '0, 1'b0, 1'b0, 1'b1);
                else
                    note_event(KIND_REMAIN, '0, line_deadline[0] - now, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    task automatic issue_command(input logic [OP_BITS-1:0] op,
                                 input logic [ID_BITS-1:0] id,
                                 input logic [DELAY_BITS-1:0] delay,
                                 input logic [NOW_BITS-1:0] now);
        @(negedge clk);
        while (take_break())
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.op       <= op;
        cmd_bus.timer_id <= id;
        cmd_bus.delay_ms <= delay;
        cmd_bus.now_us   <= now;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        model_command(op, id, delay, now);
    endtask

    task automatic check_event();
        timer_event_t want;
        if (upcoming_events.size() == 0)
        begin
            $error("unexpected event: kind %0d, id %0d", evt_bus.kind, evt_bus.expired_id);
            error_count++;
            return;
        end
        want = upcoming_events.pop_front();
        if (evt_bus.kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, evt_bus.kind);
            error_count++;
        end
        if (evt_bus.expired_id !== want.expired_id)
        begin
            $error("expired_id: expected %0d, got %0d", want.expired_id, evt_bus.expired_id);
            error_count++;
        end
        if (evt_bus.remaining_us !== want.remaining_us)
        begin
            $error("remaining_us: expected %0d, got %0d", want.remaining_us,
                   evt_bus.remaining_us);
            error_count++;
        end
        if (evt_bus.is_queued !== want.is_queued)
        begin
            $error("is_queued: expected %0d, got %0d", want.is_queued, evt_bus.is_queued);
            error_count++;
        end
        if (evt_bus.error !== want.error)
        begin
            $error("error: expected %0d, got %0d", want.error, evt_bus.error);
            error_count++;
        end
        if (evt_bus.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, evt_bus.last);
            error_count++;
        end
    endtask

    always @(negedge clk)
        evt_bus.ready <= !take_break();

    always @(posedge clk)
    begin
        if (rst_n && evt_bus.valid && evt_bus.ready)
            check_event();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (evt_bus.valid && evt_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_queue();
        issue_command(OP_STATUS, 4'd0, '0, '0);
        issue_command(OP_EXPIRE, 4'd0, '0, '0);
        issue_command(OP_CANCEL, 4'd5, '0, '0);
    endtask

    // equal deadlines pop in arm order; a re-arm moves to the back of its tie
    task automatic test_tie_order();
        issue_command(OP_ARM, 4'd3, 32'd2, 48'd1000);
        issue_command(OP_ARM, 4'd9, 32'd2, 48'd1000);
        issue_command(OP_ARM, 4'd1, 32'd2, 48'd1000);
        issue_command(OP_ARM, 4'd7, 32'd1, 48'd1000);
        issue_command(OP_ARM, 4'd3, 32'd2, 48'd1000);
        issue_command(OP_CANCEL, 4'd9, '0, '0);
        issue_command(OP_STATUS, 4'd9, '0, '0);
        issue_command(OP_STATUS, 4'd3, '0, '0);
        issue_command(OP_EXPIRE, 4'd0, '0, 48'd2000);
        issue_command(OP_EXPIRE, 4'd0, '0, 48'd3000);
    endtask

    task automatic test_saturation();
        issue_command(OP_ARM, 4'd15, '1, 48'hFFFF_FFFF_FFF0);
        issue_command(OP_ARM, 4'd0, '0, '0);
        issue_command(OP_ARM, 4'd8, '1, '0);
        issue_command(OP_EXPIRE, 4'd0, '0, '0);
        issue_command(OP_EXPIRE, 4'd0, '0, '1);
    endtask

    task automatic fill_and_drain(inout int sent);
        int order[TIMERS];
        int j;
        int tmp;
        for (int i = 0; i < TIMERS; i++)
            order[i] = i;
        for (int i = TIMERS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TIMERS; i++)
        begin
            issue_command(OP_ARM, ID_BITS'(order[i]), $urandom_range(0, 20), wall_us);
            wall_us += $urandom_range(0, 50);
        end
        wall_us += 25000;
        issue_command(OP_EXPIRE, ID_BITS'($urandom), '0, wall_us);
        sent += TIMERS + 1;
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int pick;
        logic [OP_BITS-1:0]    op;
        logic [DELAY_BITS-1:0] delay;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                fill_and_drain(sent);
            else if (pick < 14)
            begin
                issue_command(OP_BITS'($urandom), ID_BITS'($urandom), $urandom,
                              {16'($urandom), 32'($urandom)});
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                op = (pick < 45) ? OP_ARM : (pick < 60) ? OP_CANCEL :
                     (pick < 85) ? OP_EXPIRE : OP_STATUS;
                delay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8);
                wall_us += $urandom_range(0, 3000);
                issue_command(op, ID_BITS'($urandom), delay, wall_us);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.op       = OP_STATUS;
        cmd_bus.timer_id = '0;
        cmd_bus.delay_ms = '0;
        cmd_bus.now_us   = '0;
        evt_bus.ready    = 1'b0;
        line_count       = 0;
        armed_mask       = '0;
        wall_us          = '0;
        stall_enable     = 1'b1;
        error_count      = 0;
        quiet_cycles     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_tie_order();
        test_saturation();
        test_random_traffic(105);
        stall_enable = 1'b0;
        test_random_traffic(70);
        stall_enable = 1'b1;
        test_random_traffic(105);

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (upcoming_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
